// ----- hw/rtl/assert_macros.svh -----
// assertion macros for the elevator group controller checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert that a implies b on the same clock edge
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// assert that a implies b at the following clock edge
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// ----- hw/rtl/egc_pkg.sv -----
// package with shared types and constants for the elevator group controller
`timescale 1ns / 1ps
package egc_pkg;
  localparam int NumCartsDef  = 4;
  localparam int MaxLevelsDef = 16;

  typedef enum logic [1:0] {
    MODE_TICK = 2'd0, MODE_CAR = 2'd1, MODE_HALL_UP = 2'd2, MODE_HALL_DN = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    CFG_ACTIVE = 3'd0, CFG_TOP = 3'd1, CFG_IDLE = 3'd2, CFG_MOVE = 3'd3, CFG_DOOR = 3'd4
  } cfg_idx_e;

  localparam logic [2:0] M_IDLE      = 3'd0;
  localparam logic [2:0] M_IDLE_OPEN = 3'd1;
  localparam logic [2:0] M_UP        = 3'd2;
  localparam logic [2:0] M_UP_OPEN   = 3'd3;
  localparam logic [2:0] M_DOWN      = 3'd4;
  localparam logic [2:0] M_DOWN_OPEN = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_IGNORE = 2'd2;

  typedef enum logic [1:0] {
    BK_IDLE, BK_HALL, BK_TICK, BK_REPORT
  } bk_state_e;

  // classified command from the front to the back
  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] cart;
    logic [4:0] level;
    logic       bad;
  } cmd_t;

  // one result word
  typedef struct packed {
    logic [1:0] status;
    logic [1:0] cart_id;
    logic [4:0] position;
    logic [2:0] motion;
    logic [5:0] response_time;
    logic       last;
  } res_t;
endpackage

// ----- hw/rtl/egc_if.sv -----
// valid/ready stream interface carrying one word
`timescale 1ns / 1ps
interface egc_if #(parameter int W = 8) (input logic clk_i);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/egc_front.sv -----
// front end: accepts input words, checks range and queues commands
`timescale 1ns / 1ps
module egc_front
  import egc_pkg::*;
#(
  parameter int NumCarts  = NumCartsDef,
  parameter int MaxLevels = MaxLevelsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] in_mode_i,
  input  logic [1:0] in_cart_i,
  input  logic [4:0] in_level_i,
  input  logic [3:0] eff_carts_i,
  input  logic [6:0] eff_top_i,
  output logic       cmd_valid_o,
  input  logic       cmd_ready_i,
  output cmd_t       cmd_o
);
  localparam int Depth = 2;
  cmd_t       fifo_q [Depth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  cmd_t       cls;
  logic       push, pop;

  // range check of the incoming word; ticks carry no level
  always_comb begin
    cls.mode  = in_mode_i;
    cls.cart  = in_cart_i;
    cls.level = in_level_i;
    cls.bad   = (in_mode_i != MODE_TICK) &&
                ((in_level_i == 5'd0) || ({2'b0, in_level_i} > eff_top_i) ||
                 ((in_mode_i == MODE_CAR) && ({2'b0, in_cart_i} >= eff_carts_i)));
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = fifo_q[rp_q];

  // command queue storage
  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= cls;
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ----- hw/rtl/egc_back.sv -----
// back end: cart state, call assignment, stepping and reporting
`timescale 1ns / 1ps
module egc_back
  import egc_pkg::*;
#(
  parameter int NumCarts  = NumCartsDef,
  parameter int MaxLevels = MaxLevelsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  cmd_t        cmd_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [6:0]  eff_top_i,
  input  logic [3:0]  eff_carts_i,
  input  logic [15:0] idle_t_i,
  input  logic [15:0] move_t_i,
  input  logic [15:0] door_t_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output res_t        res_o
);
  localparam int CW = (NumCarts > 1) ? $clog2(NumCarts) : 1;
  localparam int L  = MaxLevels;
  localparam int PW = $clog2(MaxLevels + 1);
  typedef logic [L-1:0] mask_t;

  logic [6:0]  lvl_q [NumCarts];
  logic [2:0]  mot_q [NumCarts];
  mask_t       up_q [NumCarts], dn_q [NumCarts], st_q [NumCarts];
  logic [15:0] tmr_q [NumCarts];

  bk_state_e   st_q_, st_d;
  cmd_t        c_q;
  logic [CW:0] idx_q;
  logic [CW-1:0] best_q;
  logic [7:0]  bt_q;
  res_t        out_q;
  logic        ov_q;

  // helpers on masks
  function automatic logic [6:0] topof(mask_t m, logic [6:0] d);
    logic [6:0] r;
    r = d;
    for (int k = 0; k < L; k++) if (m[k]) r = 7'(k + 1);
    return r;
  endfunction
  function automatic logic [6:0] lowof(mask_t m, logic [6:0] d);
    logic [6:0] r;
    r = d;
    for (int k = L - 1; k >= 0; k--) if (m[k]) r = 7'(k + 1);
    return r;
  endfunction
  function automatic mask_t abv(logic [6:0] p);
    mask_t r;
    for (int k = 0; k < L; k++) r[k] = (7'(k + 1) > p);
    return r;
  endfunction
  function automatic mask_t blw(logic [6:0] p);
    mask_t r;
    for (int k = 0; k < L; k++) r[k] = (7'(k + 1) < p);
    return r;
  endfunction
  function automatic mask_t lvb(logic [4:0] v);
    mask_t r;
    for (int k = 0; k < L; k++) r[k] = (7'(k + 1) == {2'b0, v});
    return r;
  endfunction
  function automatic logic [6:0] mx(logic [6:0] a, logic [6:0] b);
    return a > b ? a : b;
  endfunction
  function automatic logic [6:0] mn(logic [6:0] a, logic [6:0] b);
    return a < b ? a : b;
  endfunction
  function automatic logic [6:0] ds(logic [6:0] a, logic [6:0] b);
    return a > b ? a - b : b - a;
  endfunction

  // response time of the current cart
  logic [CW-1:0] ci;
  logic [7:0]    rt;
  logic          upc;
  always_comb begin
    logic [6:0] p, h, l, lv;
    mask_t u, d, s;
    ci = idx_q[CW-1:0];
    p = lvl_q[ci]; u = up_q[ci]; d = dn_q[ci]; s = st_q[ci];
    lv = {2'b0, c_q.level};
    upc = (c_q.mode == MODE_HALL_UP);
    h = 7'd0; l = 7'd0;
    case (mot_q[ci])
      M_UP, M_UP_OPEN: begin
        h = mx(mx(topof(u, p), topof(d, p)), topof(s, p));
        if (upc) begin
          if (p < lv) rt = {1'b0, lv - p};
          else begin
            l = mn(lowof(u, p), lowof(d, p));
            rt = {1'b0, ds(p, h)} + {1'b0, ds(h, l)} + {1'b0, ds(l, lv)};
          end
        end else rt = {1'b0, ds(p, h)} + {1'b0, ds(h, lv)};
      end
      M_DOWN, M_DOWN_OPEN: begin
        l = mn(mn(lowof(u, p), lowof(d, p)), lowof(s, p));
        if (!upc) begin
          if (p > lv) rt = {1'b0, p - lv};
          else begin
            h = mx(topof(u, p), topof(d, p));
            rt = {1'b0, ds(p, l)} + {1'b0, ds(l, h)} + {1'b0, ds(h, lv)};
          end
        end else rt = {1'b0, ds(p, l)} + {1'b0, ds(l, lv)};
      end
      default: rt = {1'b0, ds(p, lv)};
    endcase
  end

  // step of the current cart
  logic [6:0]  sp;
  logic [2:0]  sm;
  mask_t       su, sd, ss;
  logic [15:0] stm;
  always_comb begin
    logic [6:0] p;
    logic [2:0] m;
    mask_t pb, all;
    p = lvl_q[ci]; m = mot_q[ci];
    su = up_q[ci]; sd = dn_q[ci]; ss = st_q[ci];
    if (m == M_UP && p < eff_top_i) p = p + 7'd1;
    if (m == M_DOWN && p > 7'd1) p = p - 7'd1;
    pb = '0;
    for (int k = 0; k < L; k++) pb[k] = (7'(k + 1) == p);
    all = su | sd | ss;
    sm = M_IDLE;
    case (m)
      M_IDLE: begin
        if (su != '0) begin
          if (lowof(su, p) < p) sm = M_DOWN;
          else if (lowof(su, p) == p) begin su = su & ~pb; sm = M_UP_OPEN; end
          else sm = M_UP;
        end else if (sd != '0) begin
          if (topof(sd, p) > p) sm = M_UP;
          else if (topof(sd, p) == p) begin sd = sd & ~pb; sm = M_DOWN_OPEN; end
          else sm = M_DOWN;
        end
      end
      M_UP: begin
        if ((su & pb) != '0) begin
          su = su & ~pb; ss = ss & ~pb; sm = M_UP_OPEN;
        end else if ((ss & pb) != '0) begin
          ss = ss & ~pb;
          if ((su | sd | ss) == '0) sm = M_IDLE_OPEN;
          else if (ss == '0 && mx(topof(su, p), topof(sd, p)) <= p) begin
            sd = sd & ~pb; sm = M_DOWN_OPEN;
          end else sm = M_UP_OPEN;
        end else if (((sd & pb) != '0) && topof(sd, p) == p && ss == '0 &&
                     (su == '0 || topof(su, p) < p)) begin
          sd = sd & ~pb; sm = M_DOWN_OPEN;
        end else if ((all & abv(p)) != '0) sm = M_UP;
        else if (all != '0) sm = M_DOWN;
      end
      M_DOWN: begin
        if ((sd & pb) != '0) begin
          sd = sd & ~pb; ss = ss & ~pb; sm = M_DOWN_OPEN;
        end else if ((ss & pb) != '0) begin
          ss = ss & ~pb;
          if ((su | sd | ss) == '0) sm = M_IDLE_OPEN;
          else if (ss == '0 && mn(lowof(su, p), lowof(sd, p)) >= p) begin
            su = su & ~pb; sm = M_UP_OPEN;
          end else sm = M_DOWN_OPEN;
        end else if (((su & pb) != '0) && lowof(su, p) == p && ss == '0 &&
                     (sd == '0 || lowof(sd, p) > p)) begin
          su = su & ~pb; sm = M_UP_OPEN;
        end else if ((all & blw(p)) != '0) sm = M_DOWN;
        else if (all != '0) sm = M_UP;
      end
      M_UP_OPEN: begin
        if ((all & abv(p)) != '0) sm = M_UP;
        else begin
          sd = sd & ~pb;
          sm = ((su | sd | ss) != '0) ? M_DOWN : M_IDLE;
        end
      end
      M_DOWN_OPEN: begin
        if ((all & blw(p)) != '0) sm = M_DOWN;
        else begin
          su = su & ~pb;
          sm = ((su | sd | ss) != '0) ? M_UP : M_IDLE;
        end
      end
      default: sm = M_IDLE;
    endcase
    sp = p;
    if (sm == M_IDLE) stm = idle_t_i;
    else if (sm == M_UP || sm == M_DOWN) stm = move_t_i;
    else stm = door_t_i;
    if (stm == 16'd0) stm = 16'd1;
  end

  // control
  logic out_free, lastc, carok;
  logic [CW:0] nxt;
  assign out_free    = !ov_q || res_ready_i;
  assign nxt         = idx_q + 1'b1;
  assign lastc       = (4'(nxt) >= eff_carts_i);
  assign cmd_ready_o = (st_q_ == BK_IDLE) && out_free;
  assign res_valid_o = ov_q;
  assign res_o       = out_q;

  logic [CW-1:0] ccart;
  assign ccart = cmd_i.cart[CW-1:0];
  always_comb begin
    logic [2:0] m; logic [6:0] p;
    m = mot_q[ccart]; p = lvl_q[ccart];
    carok = ((m == M_UP || m == M_UP_OPEN) && p < {2'b0, cmd_i.level}) ||
            ((m == M_DOWN || m == M_DOWN_OPEN) && p > {2'b0, cmd_i.level});
  end

  // next state
  always_comb begin
    st_d = st_q_;
    unique case (st_q_)
      BK_IDLE:
        if (cmd_valid_i && out_free && !cmd_i.bad) begin
          if (cmd_i.mode == MODE_TICK) st_d = BK_TICK;
          else if (cmd_i.mode != MODE_CAR) st_d = BK_HALL;
        end
      BK_HALL:   if (lastc && out_free) st_d = BK_IDLE;
      BK_TICK:   if (lastc) st_d = BK_REPORT;
      BK_REPORT: if (lastc && out_free) st_d = BK_IDLE;
      default:   st_d = BK_IDLE;
    endcase
  end

  // a new result word is loaded in this cycle
  logic ov_set;
  always_comb begin
    ov_set = 1'b0;
    unique case (st_q_)
      BK_IDLE:   ov_set = cmd_valid_i && out_free && (cmd_i.bad || cmd_i.mode == MODE_CAR);
      BK_HALL:   ov_set = out_free && lastc;
      BK_REPORT: ov_set = out_free;
      default:   ov_set = 1'b0;
    endcase
  end

  logic [6:0] cfg_lim;
  mask_t keep;
  always_comb begin
    for (int k = 0; k < L; k++) keep[k] = (7'(k + 1) <= eff_top_i);
    cfg_lim = eff_top_i;
  end

  // datapath and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q_ <= BK_IDLE; idx_q <= '0; ov_q <= 1'b0; best_q <= '0; bt_q <= '0;
      for (int i = 0; i < NumCarts; i++) begin
        lvl_q[i] <= 7'd1; mot_q[i] <= M_IDLE; tmr_q[i] <= 16'd2;
        up_q[i] <= '0; dn_q[i] <= '0; st_q[i] <= '0;
      end
    end else begin
      st_q_ <= st_d;
      ov_q  <= ov_set || (ov_q && !res_ready_i);
      unique case (st_q_)
        BK_IDLE: begin
          idx_q <= '0;
          if (cmd_valid_i && out_free) begin
            c_q <= cmd_i;
            if (cmd_i.bad) begin
              out_q <= '{ST_REJECT, (cmd_i.mode == MODE_CAR) ? cmd_i.cart : 2'd0,
                         5'd0, 3'd0, 6'd0, 1'b1};
            end else if (cmd_i.mode == MODE_CAR) begin
              out_q <= '{carok ? ST_OK : ST_IGNORE, cmd_i.cart,
                         lvl_q[ccart][4:0], mot_q[ccart], 6'd0, 1'b1};
              if (carok) st_q[ccart] <= st_q[ccart] | lvb(cmd_i.level);
            end
          end
        end
        BK_HALL: if (out_free) begin
          if (idx_q == '0 || rt < bt_q) begin bt_q <= rt; best_q <= ci; end
          idx_q <= nxt;
          if (lastc) begin
            logic [CW-1:0] b; logic [7:0] t;
            b = (idx_q == '0 || rt < bt_q) ? ci : best_q;
            t = (idx_q == '0 || rt < bt_q) ? rt : bt_q;
            if (upc) up_q[b] <= up_q[b] | lvb(c_q.level);
            else dn_q[b] <= dn_q[b] | lvb(c_q.level);
            out_q <= '{ST_OK, 2'(b), lvl_q[b][4:0], mot_q[b],
                       (t > 8'd63) ? 6'd63 : t[5:0], 1'b1};
          end
        end
        BK_TICK: begin
          if (tmr_q[ci] > 16'd1) tmr_q[ci] <= tmr_q[ci] - 16'd1;
          else begin
            lvl_q[ci] <= sp; mot_q[ci] <= sm; tmr_q[ci] <= stm;
            up_q[ci] <= su; dn_q[ci] <= sd; st_q[ci] <= ss;
          end
          idx_q <= lastc ? '0 : nxt;
        end
        BK_REPORT: if (out_free) begin
          out_q <= '{ST_OK, 2'(ci), lvl_q[ci][4:0], mot_q[ci], 6'd0, lastc};
          idx_q <= nxt;
        end
        default: ;
      endcase
      // a top level write trims calls and lowers carts at the write edge
      if (cfg_we_i && cfg_idx_i == CFG_TOP) begin
        for (int i = 0; i < NumCarts; i++) begin
          up_q[i] <= up_q[i] & keep; dn_q[i] <= dn_q[i] & keep;
          st_q[i] <= st_q[i] & keep;
          if (lvl_q[i] > cfg_lim) lvl_q[i] <= cfg_lim;
        end
      end
    end
  end
endmodule

// ----- hw/rtl/elevator_group_controller_unit.sv -----
// top level of the elevator group controller
// channel | dir | payload
// in_if   | in  | mode, cart, level
// out_if  | out | status, cart_id, position, motion, response_time, last
// cfg     | in  | cfg_we_i, cfg_idx_i, cfg_data_i
// each word is registered in the two-entry front queue before the back takes it
// back: a car call or reject is answered from idle, a hall call visits each active cart,
// a tick steps each active cart and then gives one report word per active cart
// reset: registers to defaults, carts idle at level one
// output stalls hold the back, but not while it steps the carts of a tick; the front queue keeps accepting until full
`timescale 1ns / 1ps
module elevator_group_controller_unit
  import egc_pkg::*;
#(
  parameter int NumCarts  = NumCartsDef,
  parameter int MaxLevels = MaxLevelsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  egc_if.sink         in_if,
  egc_if.source       out_if,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  logic [2:0]  act_q;
  logic [4:0]  top_q;
  logic [15:0] idle_q, move_q, door_q;
  logic [3:0]  eff_carts;
  logic [6:0]  eff_top, top_new;
  logic        cmd_valid, cmd_ready;
  cmd_t        cmd;
  res_t        res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 3'd3; top_q <= 5'd9; idle_q <= 16'd2; move_q <= 16'd6; door_q <= 16'd10;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ACTIVE: act_q  <= cfg_data_i[2:0];
        CFG_TOP:    top_q  <= cfg_data_i[4:0];
        CFG_IDLE:   idle_q <= cfg_data_i;
        CFG_MOVE:   move_q <= cfg_data_i;
        CFG_DOOR:   door_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamped limits; a top level write clamps with the new value at once
  function automatic logic [6:0] clamp_top(logic [4:0] t);
    logic [6:0] r;
    r = {2'b0, t};
    if (r < 7'd2) r = 7'd2;
    if (r > 7'(MaxLevels)) r = 7'(MaxLevels);
    return r;
  endfunction
  assign eff_top   = clamp_top(top_q);
  assign top_new   = clamp_top(cfg_data_i[4:0]);
  assign eff_carts = (act_q == 3'd0) ? 4'd1 :
                     ({1'b0, act_q} > 4'(NumCarts)) ? 4'(NumCarts) : {1'b0, act_q};

  egc_front #(.NumCarts(NumCarts), .MaxLevels(MaxLevels)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .in_mode_i(in_if.data[8:7]), .in_cart_i(in_if.data[6:5]), .in_level_i(in_if.data[4:0]),
    .eff_carts_i(eff_carts), .eff_top_i(eff_top),
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  egc_back #(.NumCarts(NumCarts), .MaxLevels(MaxLevels)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .cfg_we_i, .cfg_idx_i,
    .eff_top_i((cfg_we_i && cfg_idx_i == CFG_TOP) ? top_new : eff_top),
    .eff_carts_i(eff_carts),
    .idle_t_i(idle_q), .move_t_i(move_q), .door_t_i(door_q),
    .res_valid_o(out_if.valid), .res_ready_i(out_if.ready), .res_o(res)
  );
  assign out_if.data = res;
endmodule

// ----- hw/rtl/egc_checker.sv -----
// port-level checker for the elevator group controller, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module egc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [18:0] out_data
);
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid)
  `ASSERT_IMPL(a_reject_zero, clk_i, rst_ni, out_valid && out_data[18:17] == 2'd1, out_data[12:7] == 6'd0)
  `ASSERT_IMPL(a_status_ok, clk_i, rst_ni, out_valid, out_data[18:17] != 2'd3)
endmodule

bind elevator_group_controller_unit egc_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .out_data(out_if.data)
);
